@@ src/tbo_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transformed box overlap package
// Widths, number formats and item types shared by the overlap pipeline.
// ----------------------------------------------------------------------------
package tbo_pkg;

   localparam int AXES           = 3;
   localparam int COORD_BITS     = 16;
   localparam int COEF_FRAC_BITS = 14;
   localparam int COEF_BITS      = COEF_FRAC_BITS + 2;
   localparam int VEC_BITS       = AXES * COORD_BITS;
   localparam int FIELD_BITS     = 48;
   localparam int PROD_BITS      = COEF_BITS + COORD_BITS;
   // A sum of three products plus the rounding constant needs two more bits.
   localparam int SUM_BITS       = PROD_BITS + 2;
   localparam int SHIFT_BITS     = SUM_BITS - COEF_FRAC_BITS;
   localparam int TRANS_BITS     = SHIFT_BITS + 1;

   localparam logic [SUM_BITS-1:0] ROUND_HALF = SUM_BITS'(1) << (COEF_FRAC_BITS - 1);

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic signed [SUM_BITS-1:0]   sum_type;
   typedef logic [VEC_BITS-1:0]          vec_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] ref_min;
      logic [FIELD_BITS-1:0] ref_max;
      logic [FIELD_BITS-1:0] moved_min;
      logic [FIELD_BITS-1:0] moved_max;
      logic [FIELD_BITS-1:0] row_x;
      logic [FIELD_BITS-1:0] row_y;
      logic [FIELD_BITS-1:0] row_z;
      logic [FIELD_BITS-1:0] offset;
   } req_type;

   typedef struct packed {
      logic                  hit;
      logic [FIELD_BITS-1:0] overlap_min;
      logic [FIELD_BITS-1:0] overlap_max;
   } rsp_type;

endpackage

@@ src/tbo_prod.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transformed box overlap: product stage
// Forms every coefficient times both candidate corner coordinates.
// ----------------------------------------------------------------------------
module tbo_prod (
   input  logic               clock,
   input  logic               en,
   input  tbo_pkg::req_type   req,
   output tbo_pkg::prod_type  prod_lo_ff [tbo_pkg::AXES][tbo_pkg::AXES],
   output tbo_pkg::prod_type  prod_hi_ff [tbo_pkg::AXES][tbo_pkg::AXES],
   output tbo_pkg::vec_type   ref_min_ff,
   output tbo_pkg::vec_type   ref_max_ff,
   output tbo_pkg::vec_type   offset_ff
);

   localparam int CB = tbo_pkg::COORD_BITS;
   localparam int KB = tbo_pkg::COEF_BITS;
   localparam int PB = tbo_pkg::PROD_BITS;
   localparam int NA = tbo_pkg::AXES;
   localparam int VB = tbo_pkg::VEC_BITS;

   logic [tbo_pkg::FIELD_BITS-1:0] row [NA];
   tbo_pkg::coord_type             mmin_s [NA];
   tbo_pkg::coord_type             mmax_s [NA];
   logic signed [KB-1:0]           coef_s [NA][NA];
   tbo_pkg::prod_type              prod_lo_in [NA][NA];
   tbo_pkg::prod_type              prod_hi_in [NA][NA];

   always_comb begin
      row[0] = req.row_x;
      row[1] = req.row_y;
      row[2] = req.row_z;
      for (int k = 0; k < NA; k++) begin
         mmin_s[k] = $signed(req.moved_min[k*CB +: CB]);
         mmax_s[k] = $signed(req.moved_max[k*CB +: CB]);
      end
      // Each axis sum is separable, so the extreme corner is chosen per term later.
      for (int a = 0; a < NA; a++) begin
         for (int k = 0; k < NA; k++) begin
            coef_s[a][k]     = $signed(row[a][k*KB +: KB]);
            prod_lo_in[a][k] = PB'(coef_s[a][k]) * PB'(mmin_s[k]);
            prod_hi_in[a][k] = PB'(coef_s[a][k]) * PB'(mmax_s[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_lo_ff <= prod_lo_in;
         prod_hi_ff <= prod_hi_in;
         ref_min_ff <= req.ref_min[VB-1:0];
         ref_max_ff <= req.ref_max[VB-1:0];
         offset_ff  <= req.offset[VB-1:0];
      end
   end

endmodule

@@ src/tbo_bound.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transformed box overlap: bounds stages
// Sums the per-term extremes, then rounds, offsets and saturates each bound.
// ----------------------------------------------------------------------------
module tbo_bound (
   input  logic               clock,
   input  logic               en_sum,
   input  logic               en_rnd,
   input  tbo_pkg::prod_type  prod_lo [tbo_pkg::AXES][tbo_pkg::AXES],
   input  tbo_pkg::prod_type  prod_hi [tbo_pkg::AXES][tbo_pkg::AXES],
   input  tbo_pkg::vec_type   ref_min,
   input  tbo_pkg::vec_type   ref_max,
   input  tbo_pkg::vec_type   offset,
   output tbo_pkg::coord_type bmin_ff [tbo_pkg::AXES],
   output tbo_pkg::coord_type bmax_ff [tbo_pkg::AXES],
   output tbo_pkg::vec_type   ref_min_ff,
   output tbo_pkg::vec_type   ref_max_ff
);

   localparam int CB  = tbo_pkg::COORD_BITS;
   localparam int SB  = tbo_pkg::SUM_BITS;
   localparam int SHB = tbo_pkg::SHIFT_BITS;
   localparam int TB  = tbo_pkg::TRANS_BITS;
   localparam int NA  = tbo_pkg::AXES;

   tbo_pkg::sum_type   smin_ff [NA];
   tbo_pkg::sum_type   smax_ff [NA];
   tbo_pkg::sum_type   smin_in [NA];
   tbo_pkg::sum_type   smax_in [NA];
   tbo_pkg::vec_type   ref_min2_ff;
   tbo_pkg::vec_type   ref_max2_ff;
   tbo_pkg::vec_type   offset2_ff;
   tbo_pkg::coord_type bmin_in [NA];
   tbo_pkg::coord_type bmax_in [NA];

   function automatic tbo_pkg::coord_type sat_coord(input logic signed [TB-1:0] t);
      if (&t[TB-1:CB-1] || ~|t[TB-1:CB-1]) begin
         return t[CB-1:0];
      end else if (t[TB-1]) begin
         return {1'b1, {(CB-1){1'b0}}};
      end else begin
         return {1'b0, {(CB-1){1'b1}}};
      end
   endfunction

   // Rounding, flooring and saturation are monotonic, so the bounds of the
   // transformed corners follow from the smallest and largest exact sums.
   always_comb begin
      tbo_pkg::prod_type mn;
      tbo_pkg::prod_type mx;
      for (int a = 0; a < NA; a++) begin
         smin_in[a] = $signed(tbo_pkg::ROUND_HALF);
         smax_in[a] = $signed(tbo_pkg::ROUND_HALF);
         for (int k = 0; k < NA; k++) begin
            if (prod_lo[a][k] < prod_hi[a][k]) begin
               mn = prod_lo[a][k];
               mx = prod_hi[a][k];
            end else begin
               mn = prod_hi[a][k];
               mx = prod_lo[a][k];
            end
            smin_in[a] = smin_in[a] + SB'(mn);
            smax_in[a] = smax_in[a] + SB'(mx);
         end
      end
   end

   always_comb begin
      tbo_pkg::sum_type   shl;
      tbo_pkg::sum_type   shh;
      tbo_pkg::coord_type off_s;
      logic signed [TB-1:0] tl;
      logic signed [TB-1:0] th;
      for (int a = 0; a < NA; a++) begin
         shl   = smin_ff[a] >>> tbo_pkg::COEF_FRAC_BITS;
         shh   = smax_ff[a] >>> tbo_pkg::COEF_FRAC_BITS;
         off_s = $signed(offset2_ff[a*CB +: CB]);
         tl    = TB'($signed(shl[SHB-1:0])) + TB'(off_s);
         th    = TB'($signed(shh[SHB-1:0])) + TB'(off_s);
         bmin_in[a] = sat_coord(tl);
         bmax_in[a] = sat_coord(th);
      end
   end

   always_ff @(posedge clock) begin
      if (en_sum) begin
         smin_ff     <= smin_in;
         smax_ff     <= smax_in;
         ref_min2_ff <= ref_min;
         ref_max2_ff <= ref_max;
         offset2_ff  <= offset;
      end
      if (en_rnd) begin
         bmin_ff    <= bmin_in;
         bmax_ff    <= bmax_in;
         ref_min_ff <= ref_min2_ff;
         ref_max_ff <= ref_max2_ff;
      end
   end

endmodule

@@ src/tbo_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transformed box overlap: test stage
// Strict overlap test against the reference box and overlap box output.
// ----------------------------------------------------------------------------
module tbo_test (
   input  logic               clock,
   input  logic               en,
   input  tbo_pkg::coord_type bmin [tbo_pkg::AXES],
   input  tbo_pkg::coord_type bmax [tbo_pkg::AXES],
   input  tbo_pkg::vec_type   ref_min,
   input  tbo_pkg::vec_type   ref_max,
   output tbo_pkg::rsp_type   rsp_ff
);

   localparam int CB = tbo_pkg::COORD_BITS;
   localparam int FB = tbo_pkg::FIELD_BITS;
   localparam int NA = tbo_pkg::AXES;

   tbo_pkg::rsp_type rsp_in;
   tbo_pkg::vec_type omin_v;
   tbo_pkg::vec_type omax_v;
   logic             hit;

   always_comb begin
      tbo_pkg::coord_type rmin;
      tbo_pkg::coord_type rmax;
      hit = 1'b1;
      for (int a = 0; a < NA; a++) begin
         rmin = $signed(ref_min[a*CB +: CB]);
         rmax = $signed(ref_max[a*CB +: CB]);
         if (bmin[a] >= rmax || bmax[a] <= rmin) begin
            hit = 1'b0;
         end
         omin_v[a*CB +: CB] = (bmin[a] > rmin) ? bmin[a] : rmin;
         omax_v[a*CB +: CB] = (bmax[a] < rmax) ? bmax[a] : rmax;
      end
      rsp_in.hit         = hit;
      rsp_in.overlap_min = hit ? FB'(omin_v) : '0;
      rsp_in.overlap_max = hit ? FB'(omax_v) : '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

@@ src/transformed_box_overlap_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transformed box overlap core
// Transforms a box by an affine map, bounds it and tests it against a reference.
// ----------------------------------------------------------------------------
// An accepted item passes through the product, sum, round and test stage registers in turn.
// Throughput: one item per cycle; each of the four stages holds its item while
// stalled and takes a new one as soon as it is empty or draining.
// Reset clears all stage valid bits; the datapath registers are not reset.
module transformed_box_overlap_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tbo_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tbo_pkg::rsp_type rsp_data
);

   localparam int NA = tbo_pkg::AXES;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic en1, en2, en3, en4;

   tbo_pkg::prod_type  prod_lo [NA][NA];
   tbo_pkg::prod_type  prod_hi [NA][NA];
   tbo_pkg::vec_type   ref_min1, ref_max1, offset1;
   tbo_pkg::coord_type bmin [NA];
   tbo_pkg::coord_type bmax [NA];
   tbo_pkg::vec_type   ref_min3, ref_max3;

   // A stage loads when it is empty or its contents move on in the same cycle.
   always_comb begin
      en4   = !v4_ff || !rsp_stall;
      en3   = !v3_ff || en4;
      en2   = !v2_ff || en3;
      en1   = !v1_ff || en2;
      v1_in = en1 ? req_valid : v1_ff;
      v2_in = en2 ? v1_ff : v2_ff;
      v3_in = en3 ? v2_ff : v3_ff;
      v4_in = en4 ? v3_ff : v4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   assign req_stall = !en1;
   assign rsp_valid = v4_ff;

   tbo_prod u_prod (
      .clock      (clock),
      .en         (en1),
      .req        (req_data),
      .prod_lo_ff (prod_lo),
      .prod_hi_ff (prod_hi),
      .ref_min_ff (ref_min1),
      .ref_max_ff (ref_max1),
      .offset_ff  (offset1)
   );

   tbo_bound u_bound (
      .clock      (clock),
      .en_sum     (en2),
      .en_rnd     (en3),
      .prod_lo    (prod_lo),
      .prod_hi    (prod_hi),
      .ref_min    (ref_min1),
      .ref_max    (ref_max1),
      .offset     (offset1),
      .bmin_ff    (bmin),
      .bmax_ff    (bmax),
      .ref_min_ff (ref_min3),
      .ref_max_ff (ref_max3)
   );

   tbo_test u_test (
      .clock   (clock),
      .en      (en4),
      .bmin    (bmin),
      .bmax    (bmax),
      .ref_min (ref_min3),
      .ref_max (ref_max3),
      .rsp_ff  (rsp_data)
   );

endmodule

@@ verif/transformed_box_overlap_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transformed box overlap core testbench
// Streams box pairs with affine transforms through the core under random
// idling on both channels, predicts every overlap result in the testbench and
// compares each returned result field by field, in order.
// ----------------------------------------------------------------------------
module transformed_box_overlap_core_tb;

   localparam int COORD_BITS     = tbo_pkg::COORD_BITS;
   localparam int COEF_BITS      = tbo_pkg::COEF_BITS;
   localparam int COEF_FRAC_BITS = tbo_pkg::COEF_FRAC_BITS;
   localparam int FIELD_BITS     = tbo_pkg::FIELD_BITS;
   localparam int ONE            = 1 << COEF_FRAC_BITS;
   localparam int COORD_MAX      = (1 << (COORD_BITS - 1)) - 1;
   localparam int COORD_MIN      = -COORD_MAX - 1;
   localparam int COEF_MAX       = (1 << (COEF_BITS - 1)) - 1;
   localparam int COEF_MIN       = -COEF_MAX - 1;
   localparam int RANDOM_ITEMS   = 1300;
   localparam int TAIL_ITEMS     = 200;
   localparam int HOLD_AT_RESULT = 300;
   localparam int HOLD_CYCLES    = 150;
   localparam int DRAIN_CYCLES   = 20;
   localparam int WATCHDOG_LIMIT = 4000;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   tbo_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   tbo_pkg::rsp_type rsp_data;

   tbo_pkg::req_type box_pairs_pending[$];
   tbo_pkg::rsp_type overlap_expected[$];
   logic    idle_ok   = 1'b0;
   logic    long_hold = 1'b0;
   int      send_gap  = 0;
   int      recv_gap  = 0;
   int      hold_left = 0;
   bit      hold_done = 0;
   int      results_seen = 0;
   int      mismatches   = 0;
   int      quiet_cycles = 0;

   transformed_box_overlap_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Transforms the eight corners, bounds them and intersects with the
   // reference box.
   function automatic tbo_pkg::rsp_type predict_overlap(input tbo_pkg::req_type r);
      logic [FIELD_BITS-1:0]       rows[3];
      logic signed [COEF_BITS-1:0] coef_lane;
      longint rmin[3], rmax[3], mmin[3], mmax[3], off[3];
      longint bmin[3], bmax[3], omin[3], omax[3], p[3];
      longint coef[3][3];
      longint s, t;
      bit     hit;
      tbo_pkg::rsp_type res;
      rows = '{r.row_x, r.row_y, r.row_z};
      res  = '0;
      hit  = 1'b1;
      for (int a = 0; a < 3; a++) begin
         rmin[a] = tbo_pkg::coord_type'(r.ref_min[a*COORD_BITS +: COORD_BITS]);
         rmax[a] = tbo_pkg::coord_type'(r.ref_max[a*COORD_BITS +: COORD_BITS]);
         mmin[a] = tbo_pkg::coord_type'(r.moved_min[a*COORD_BITS +: COORD_BITS]);
         mmax[a] = tbo_pkg::coord_type'(r.moved_max[a*COORD_BITS +: COORD_BITS]);
         off[a]  = tbo_pkg::coord_type'(r.offset[a*COORD_BITS +: COORD_BITS]);
         for (int b = 0; b < 3; b++) begin
            coef_lane  = rows[a][b*COEF_BITS +: COEF_BITS];
            coef[a][b] = coef_lane;
         end
      end
      for (int c = 0; c < 8; c++) begin
         p[0] = (c & 4) ? mmax[0] : mmin[0];
         p[1] = (c & 2) ? mmax[1] : mmin[1];
         p[2] = (c & 1) ? mmax[2] : mmin[2];
         for (int a = 0; a < 3; a++) begin
            s = coef[a][0] * p[0] + coef[a][1] * p[1] + coef[a][2] * p[2];
            s = s + (longint'(1) << (COEF_FRAC_BITS - 1));
            // Arithmetic shift floors, which gives round half up overall.
            t = (s >>> COEF_FRAC_BITS) + off[a];
            if (t > COORD_MAX) t = COORD_MAX;
            if (t < COORD_MIN) t = COORD_MIN;
            if (c == 0 || t < bmin[a]) bmin[a] = t;
            if (c == 0 || t > bmax[a]) bmax[a] = t;
         end
      end
      for (int a = 0; a < 3; a++) begin
         if (bmin[a] >= rmax[a] || bmax[a] <= rmin[a]) hit = 1'b0;
         omin[a] = (bmin[a] > rmin[a]) ? bmin[a] : rmin[a];
         omax[a] = (bmax[a] < rmax[a]) ? bmax[a] : rmax[a];
      end
      res.hit = hit;
      if (hit) begin
         for (int a = 0; a < 3; a++) begin
            res.overlap_min[a*COORD_BITS +: COORD_BITS] = COORD_BITS'(omin[a]);
            res.overlap_max[a*COORD_BITS +: COORD_BITS] = COORD_BITS'(omax[a]);
         end
      end
      return res;
   endfunction

   function automatic logic [FIELD_BITS-1:0] vec3(input int x, input int y, input int z);
      return FIELD_BITS'({COORD_BITS'(z), COORD_BITS'(y), COORD_BITS'(x)});
   endfunction

   function automatic logic [FIELD_BITS-1:0] row3(input int c0, input int c1, input int c2);
      return FIELD_BITS'({COEF_BITS'(c2), COEF_BITS'(c1), COEF_BITS'(c0)});
   endfunction

   function automatic int span(input int lo, input int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   function automatic int extreme_lane();
      case ($urandom_range(0, 4))
         0:       return COORD_MIN;
         1:       return COORD_MAX;
         2:       return 0;
         3:       return -1;
         default: return span(COORD_MIN, COORD_MAX);
      endcase
   endfunction

   function automatic logic [FIELD_BITS-1:0] noise();
      return FIELD_BITS'({$urandom, $urandom});
   endfunction

   task automatic add_box_pair(input logic [FIELD_BITS-1:0] rmn, rmx, mmn, mmx,
                               input logic [FIELD_BITS-1:0] rx, ry, rz, off);
      tbo_pkg::req_type item;
      item.ref_min   = rmn;
      item.ref_max   = rmx;
      item.moved_min = mmn;
      item.moved_max = mmx;
      item.row_x     = rx;
      item.row_y     = ry;
      item.row_z     = rz;
      item.offset    = off;
      box_pairs_pending.push_back(item);
   endtask

   // Mostly ordered boxes under moderate transforms so that hits are common,
   // plus wide ranges, pure noise, extreme lanes and edge-touching pairs.
   task automatic add_random_pair();
      int kind, touch;
      int rmn[3], rmx[3], mmn[3], mmx[3], off[3];
      int cf[3][3];
      kind  = $urandom_range(0, 9);
      touch = $urandom_range(0, 3);
      for (int a = 0; a < 3; a++) begin
         rmn[a] = span(-2000, 2000);
         rmx[a] = rmn[a] + span(1, 3000);
         mmn[a] = span(-1500, 1500);
         mmx[a] = mmn[a] + span(0, 2000);
         off[a] = span(-1500, 1500);
         for (int b = 0; b < 3; b++) cf[a][b] = span(-ONE, ONE);
         if (kind == 6) begin
            rmn[a] = span(COORD_MIN, COORD_MAX);
            rmx[a] = span(COORD_MIN, COORD_MAX);
            mmn[a] = span(COORD_MIN, COORD_MAX);
            mmx[a] = span(COORD_MIN, COORD_MAX);
            off[a] = span(COORD_MIN, COORD_MAX);
            for (int b = 0; b < 3; b++) cf[a][b] = span(COEF_MIN, COEF_MAX);
         end else if (kind == 8) begin
            rmn[a] = extreme_lane();
            rmx[a] = extreme_lane();
            mmn[a] = extreme_lane();
            mmx[a] = extreme_lane();
            off[a] = extreme_lane();
            for (int b = 0; b < 3; b++) cf[a][b] = extreme_lane();
         end else if (kind == 9) begin
            off[a] = 0;
            for (int b = 0; b < 3; b++) cf[a][b] = (a == b) ? ONE : 0;
            mmn[a] = rmn[a];
            mmx[a] = rmx[a];
            if (a == touch) begin
               if ($urandom_range(0, 1)) begin
                  mmn[a] = rmx[a];
                  mmx[a] = rmx[a] + span(0, 500);
               end else begin
                  mmx[a] = rmn[a];
                  mmn[a] = rmn[a] - span(0, 500);
               end
            end
         end
      end
      if (kind == 7)
         add_box_pair(noise(), noise(), noise(), noise(), noise(), noise(), noise(), noise());
      else
         add_box_pair(vec3(rmn[0], rmn[1], rmn[2]), vec3(rmx[0], rmx[1], rmx[2]),
                      vec3(mmn[0], mmn[1], mmn[2]), vec3(mmx[0], mmx[1], mmx[2]),
                      row3(cf[0][0], cf[0][1], cf[0][2]),
                      row3(cf[1][0], cf[1][1], cf[1][2]),
                      row3(cf[2][0], cf[2][1], cf[2][2]),
                      vec3(off[0], off[1], off[2]));
   endtask

   // Request driver: holds an offered item until it is taken, then inserts
   // random gaps while idling is allowed.
   always @(posedge clock) begin : drive_requests
      logic offer;
      offer = req_valid;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            overlap_expected.push_back(predict_overlap(req_data));
            offer = 1'b0;
         end
         if (long_hold) send_gap = 0;
         if (!offer) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (box_pairs_pending.size() > 0) begin
               req_data <= box_pairs_pending.pop_front();
               offer = 1'b1;
               if (idle_ok && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 18);
            end
         end
         req_valid <= offer;
         // Idling pauses in every third stretch and stops for the tail.
         idle_ok <= (box_pairs_pending.size() > TAIL_ITEMS) &&
                    ((box_pairs_pending.size() / 160) % 3 != 2);
      end
   end

   // Result monitor and receiver stall control.
   always @(posedge clock) begin : collect_results
      tbo_pkg::rsp_type want;
      logic             stall_next;
      if (reset) begin
         rsp_stall <= 1'b0;
         long_hold <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (overlap_expected.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result %0d: hit=%0b min=%h max=%h", results_seen,
                           rsp_data.hit, rsp_data.overlap_min, rsp_data.overlap_max);
            end else begin
               want = overlap_expected.pop_front();
               if (rsp_data.hit !== want.hit || rsp_data.overlap_min !== want.overlap_min ||
                   rsp_data.overlap_max !== want.overlap_max) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"result %0d: expected hit=%0b min=%h max=%h, ",
                               "got hit=%0b min=%h max=%h"},
                              results_seen, want.hit, want.overlap_min, want.overlap_max,
                              rsp_data.hit, rsp_data.overlap_min, rsp_data.overlap_max);
               end
            end
         end
         stall_next = 1'b0;
         if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
            // One long hold-off so the pipeline fills and backs up the input.
            hold_done = 1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else if (recv_gap > 0) begin
            recv_gap--;
            stall_next = 1'b1;
         end else if (idle_ok && $urandom_range(0, 7) == 0) begin
            recv_gap   = $urandom_range(0, 17);
            stall_next = 1'b1;
         end
         rsp_stall <= stall_next;
         long_hold <= (hold_left > 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [FIELD_BITS-1:0] id_x, id_y, id_z, zero;
      id_x = row3(ONE, 0, 0);
      id_y = row3(0, ONE, 0);
      id_z = row3(0, 0, ONE);
      zero = '0;

      // Identity transform: plain overlap, clear miss, and touching faces.
      add_box_pair(vec3(-100, -100, -100), vec3(100, 100, 100), vec3(0, 0, 0),
                   vec3(50, 50, 50), id_x, id_y, id_z, zero);
      add_box_pair(vec3(-100, -100, -100), vec3(100, 100, 100), vec3(200, 200, 200),
                   vec3(300, 300, 300), id_x, id_y, id_z, zero);
      add_box_pair(vec3(-100, -100, -100), vec3(100, 100, 100), vec3(100, 100, 100),
                   vec3(150, 150, 150), id_x, id_y, id_z, zero);
      add_box_pair(vec3(-100, -100, -100), vec3(100, 100, 100), vec3(-150, -150, -150),
                   vec3(-100, -100, -100), id_x, id_y, id_z, zero);
      add_box_pair(vec3(-100, -100, -100), vec3(100, 100, 100), vec3(100, 0, 0),
                   vec3(150, 50, 50), id_x, id_y, id_z, zero);
      // Offset carries a distant box onto the reference.
      add_box_pair(vec3(-100, -100, -100), vec3(100, 100, 100), vec3(500, 500, 500),
                   vec3(600, 600, 600), id_x, id_y, id_z, vec3(-550, -550, -550));
      // Quarter turn about z, and a scale of minus two.
      add_box_pair(vec3(-100, -100, -100), vec3(100, 100, 100), vec3(10, 20, 30),
                   vec3(40, 90, 60), row3(0, -ONE, 0), row3(ONE, 0, 0), id_z, zero);
      add_box_pair(vec3(-100, -100, -100), vec3(0, 0, 0), vec3(10, 10, 10),
                   vec3(20, 20, 20), row3(COEF_MIN, 0, 0), row3(0, COEF_MIN, 0),
                   row3(0, 0, COEF_MIN), zero);
      // Saturation at both ends of the coordinate range.
      add_box_pair(vec3(0, 0, 0), vec3(COORD_MAX, COORD_MAX, COORD_MAX),
                   vec3(10000, 10000, 10000), vec3(20000, 20000, 20000),
                   row3(COEF_MAX, 0, 0), row3(0, COEF_MAX, 0), row3(0, 0, COEF_MAX), zero);
      add_box_pair(vec3(COORD_MIN, COORD_MIN, COORD_MIN), vec3(0, 0, 0),
                   vec3(10000, 10000, 10000), vec3(20000, 20000, 20000),
                   row3(COEF_MIN, 0, 0), row3(0, COEF_MIN, 0), row3(0, 0, COEF_MIN), zero);
      add_box_pair(vec3(COORD_MIN, COORD_MIN, COORD_MIN), vec3(COORD_MAX, COORD_MAX, COORD_MAX),
                   vec3(32000, 32000, 32000), vec3(32700, 32700, 32700), id_x, id_y, id_z,
                   vec3(COORD_MAX, COORD_MAX, COORD_MAX));
      add_box_pair(vec3(COORD_MIN, COORD_MIN, COORD_MIN), vec3(COORD_MAX, COORD_MAX, COORD_MAX),
                   vec3(COORD_MIN, COORD_MIN, COORD_MIN), vec3(COORD_MAX, COORD_MAX, COORD_MAX),
                   row3(COEF_MIN, COEF_MAX, COEF_MIN), row3(COEF_MAX, COEF_MAX, COEF_MAX),
                   row3(COEF_MIN, COEF_MIN, COEF_MIN), vec3(COORD_MIN, 0, COORD_MAX));
      // Half-way values round toward plus infinity.
      add_box_pair(vec3(0, 0, 0), vec3(1, 10, 10), vec3(-1, 0, 0), vec3(1, 5, 5),
                   row3(ONE / 2, 0, 0), id_y, id_z, zero);
      add_box_pair(vec3(-5, -5, -5), vec3(5, 5, 5), vec3(-3, -3, -3), vec3(3, 3, 3),
                   row3(ONE / 2, 0, 0), row3(0, -ONE / 2, 0), row3(0, 0, ONE / 2), zero);
      // All-zero and all-one items: degenerate boxes that miss.
      add_box_pair(zero, zero, zero, zero, zero, zero, zero, zero);
      add_box_pair('1, '1, '1, '1, '1, '1, '1, '1);
      // Inverted reference box: a miss, then a hit whose overlap is inverted too.
      add_box_pair(vec3(100, 100, 100), vec3(-100, -100, -100), vec3(0, 0, 0),
                   vec3(50, 50, 50), id_x, id_y, id_z, zero);
      add_box_pair(vec3(100, 100, 100), vec3(-100, -100, -100), vec3(-200, -200, -200),
                   vec3(200, 200, 200), id_x, id_y, id_z, zero);
      // Inverted moved box still bounds all of its corners.
      add_box_pair(vec3(-10, -10, -10), vec3(10, 10, 10), vec3(50, 50, 50),
                   vec3(-50, -50, -50), id_x, id_y, id_z, zero);
      // Zero transform collapses the box to the offset point.
      add_box_pair(vec3(0, 0, 0), vec3(10, 10, 10), vec3(-300, -300, -300),
                   vec3(300, 300, 300), zero, zero, zero, vec3(5, 5, 5));
      // Full-range reference, and a reference box of zero size.
      add_box_pair(vec3(COORD_MIN, COORD_MIN, COORD_MIN), vec3(COORD_MAX, COORD_MAX, COORD_MAX),
                   vec3(COORD_MIN, COORD_MIN, COORD_MIN), vec3(COORD_MAX, COORD_MAX, COORD_MAX),
                   id_x, id_y, id_z, zero);
      add_box_pair(vec3(5, 5, 5), vec3(5, 5, 5), vec3(0, 0, 0), vec3(10, 10, 10),
                   id_x, id_y, id_z, zero);

      repeat (RANDOM_ITEMS) add_random_pair();

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      while (box_pairs_pending.size() != 0 || req_valid || overlap_expected.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && overlap_expected.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
